// ===== rtl/cpse_pkg.sv =====
// Shared types and constants for the convolution engine.
package cpse_pkg;

	localparam int IMAGE_WORDS = 16384;
	localparam int WEIGHT_WORDS = 16384;
	localparam int MAX_OUT_CH = 16;
	localparam int MAX_DIM = 64;
	localparam int MAX_KERNEL = 7;
	localparam int IMG_AW = $clog2(IMAGE_WORDS);
	localparam int WGT_AW = $clog2(WEIGHT_WORDS);
	localparam int NCH_W = $clog2(MAX_OUT_CH);
	localparam int ACC_W = 40;
	// wide enough for any address product before range check
	localparam int ADDR_W = 24;

	localparam logic [1:0] OP_LOAD_IMG = 2'd0;
	localparam logic [1:0] OP_LOAD_WGT = 2'd1;
	localparam logic [1:0] OP_LOAD_BIAS = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	localparam logic [2:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH = 3'd1;
	localparam logic [2:0] REG_IN_CHANNELS = 3'd2;
	localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
	localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd4;
	localparam logic [2:0] REG_KERNEL_WIDTH = 3'd5;
	localparam logic [2:0] REG_STRIDE = 3'd6;
	localparam logic [2:0] REG_PAD = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BIAS,
		ST_BIAS_WAIT,
		ST_POS,
		ST_IADDR,
		ST_IREAD,
		ST_MAC,
		ST_MAC_WAIT,
		ST_NEXT,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic bias_rd;      // read bias[n] and load accumulator n
		logic pos_calc;     // compute row/col of tap, in bounds flag
		logic iaddr_calc;   // form image address for tap, channel
		logic img_rd;       // issue image read
		logic wgt_rd;       // issue weight read for n
		logic mac;          // accumulate into n
		logic out_calc;     // round accumulator n into the output register
		logic [NCH_W-1:0] n;
		logic [2:0] i;
		logic [2:0] j;
		logic [5:0] c;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_bounds;
		logic act_zero;
	} stat_t;

	typedef struct packed {
		logic [6:0] h;
		logic [6:0] w;
		logic [6:0] c;
		logic [4:0] n;
		logic [2:0] kh;
		logic [2:0] kw;
		logic [2:0] s;
		logic [1:0] p;
	} geom_t;

endpackage

// ===== rtl/conv2d_pad_stride_engine.sv =====
// Top level: configuration registers, input handshake, controller and datapath.
// Loads produce no result.
// A compute transaction is carried out by one shared multiply-accumulate unit
// stepping through channels and taps; a tap in the border skips its input
// channels, and a zero image word skips the weights of that channel.
// One compute transaction is in flight at a time; results leave through a
// registered output. arst_n resets control state and the configuration.
module conv2d_pad_stride_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic [1:0]         operation,
	input  logic [13:0]        index,
	input  logic signed [15:0] value,
	input  logic [5:0]         out_row,
	input  logic [5:0]         out_col,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] result_value,
	output logic [3:0]         channel,
	output logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	logic [6:0] h_q, w_q, c_q;
	logic [4:0] n_q;
	logic [2:0] kh_q, kw_q, s_q;
	logic [1:0] p_q;
	cpse_pkg::geom_t geom;
	cpse_pkg::cmd_t cmd;
	cpse_pkg::stat_t stat;
	logic busy, acc, start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= 7'd1;
			w_q <= 7'd1;
			c_q <= 7'd1;
			n_q <= 5'd1;
			kh_q <= 3'd1;
			kw_q <= 3'd1;
			s_q <= 3'd1;
			p_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpse_pkg::REG_IN_HEIGHT: h_q <= cfg_data;
				cpse_pkg::REG_IN_WIDTH: w_q <= cfg_data;
				cpse_pkg::REG_IN_CHANNELS: c_q <= cfg_data;
				cpse_pkg::REG_OUT_CHANNELS: n_q <= cfg_data[4:0];
				cpse_pkg::REG_KERNEL_HEIGHT: kh_q <= cfg_data[2:0];
				cpse_pkg::REG_KERNEL_WIDTH: kw_q <= cfg_data[2:0];
				cpse_pkg::REG_STRIDE: s_q <= cfg_data[2:0];
				cpse_pkg::REG_PAD: p_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// clamp register values into their working ranges
	assign geom.h = (h_q == 0) ? 7'd1 : (h_q > 7'd64) ? 7'd64 : h_q;
	assign geom.w = (w_q == 0) ? 7'd1 : (w_q > 7'd64) ? 7'd64 : w_q;
	assign geom.c = (c_q == 0) ? 7'd1 : (c_q > 7'd64) ? 7'd64 : c_q;
	assign geom.n = (n_q == 0) ? 5'd1 : (n_q > 5'd16) ? 5'd16 : n_q;
	assign geom.kh = (kh_q == 0) ? 3'd1 : kh_q;
	assign geom.kw = (kw_q == 0) ? 3'd1 : kw_q;
	assign geom.s = (s_q == 0) ? 3'd1 : (s_q > 3'd4) ? 3'd4 : s_q;
	assign geom.p = p_q;

	assign stall = busy;
	assign acc = valid && !stall;
	assign start = acc && (operation == cpse_pkg::OP_COMPUTE);

	cpse_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.geom(geom),
		.stat(stat),
		.out_stall(result_stall),
		.busy(busy),
		.out_valid(result_valid),
		.out_last(last),
		.cmd(cmd)
	);

	cpse_dp u_dp (
		.clk(clk),
		.ld_en(acc),
		.ld_op(operation),
		.ld_index(index),
		.ld_value(value),
		.start(start),
		.row(out_row),
		.col(out_col),
		.geom(geom),
		.cmd(cmd),
		.stat(stat),
		.res_value(result_value),
		.res_channel(channel)
	);

endmodule

// ===== rtl/cpse_ctrl.sv =====
// Controller state machine: walks channels, taps and input channels.
module cpse_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cpse_pkg::geom_t       geom,
	input  cpse_pkg::stat_t       stat,
	input  logic                  out_stall,
	output logic                  busy,
	output logic                  out_valid,
	output logic                  out_last,
	output cpse_pkg::cmd_t        cmd
);

	cpse_pkg::state_t state_q, state_d;
	logic [cpse_pkg::NCH_W-1:0] n_q, n_d;
	logic [2:0] i_q, i_d, j_q, j_d;
	logic [5:0] c_q, c_d;
	logic valid_q, valid_d;
	logic last_q, last_d;
	logic [cpse_pkg::NCH_W-1:0] nl;
	logic [2:0] kl_h, kl_w;
	logic [5:0] cl;

	assign nl = cpse_pkg::NCH_W'(geom.n - 5'd1);
	assign kl_h = geom.kh - 3'd1;
	assign kl_w = geom.kw - 3'd1;
	assign cl = 6'(geom.c - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpse_pkg::ST_IDLE;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			c_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q <= n_d;
			i_q <= i_d;
			j_q <= j_d;
			c_q <= c_d;
			valid_q <= valid_d;
			last_q <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		n_d = n_q;
		i_d = i_q;
		j_d = j_q;
		c_d = c_q;
		valid_d = valid_q;
		last_d = last_q;
		cmd = '0;
		cmd.n = n_q;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.c = c_q;
		if (valid_q && !out_stall) valid_d = 1'b0;
		unique case (state_q)
			cpse_pkg::ST_IDLE: begin
				if (start) begin
					n_d = '0;
					state_d = cpse_pkg::ST_BIAS;
				end
			end
			cpse_pkg::ST_BIAS: begin
				cmd.bias_rd = 1'b1;
				state_d = cpse_pkg::ST_BIAS_WAIT;
			end
			cpse_pkg::ST_BIAS_WAIT: begin
				if (n_q == nl) begin
					i_d = '0;
					j_d = '0;
					c_d = '0;
					n_d = '0;
					state_d = cpse_pkg::ST_POS;
				end else begin
					n_d = n_q + 1'b1;
					state_d = cpse_pkg::ST_BIAS;
				end
			end
			cpse_pkg::ST_POS: begin
				cmd.pos_calc = 1'b1;
				state_d = cpse_pkg::ST_IADDR;
			end
			cpse_pkg::ST_IADDR: begin
				if (!stat.in_bounds) begin
					state_d = cpse_pkg::ST_NEXT;
					c_d = cl;
				end else begin
					cmd.iaddr_calc = 1'b1;
					state_d = cpse_pkg::ST_IREAD;
				end
			end
			cpse_pkg::ST_IREAD: begin
				cmd.img_rd = 1'b1;
				n_d = '0;
				state_d = cpse_pkg::ST_MAC;
			end
			cpse_pkg::ST_MAC: begin
				// image word valid here; skip the channel when it is zero
				if (stat.act_zero) begin
					state_d = cpse_pkg::ST_NEXT;
				end else begin
					cmd.wgt_rd = 1'b1;
					state_d = cpse_pkg::ST_MAC_WAIT;
				end
			end
			cpse_pkg::ST_MAC_WAIT: begin
				cmd.mac = 1'b1;
				if (n_q == nl) begin
					state_d = cpse_pkg::ST_NEXT;
				end else begin
					n_d = n_q + 1'b1;
					state_d = cpse_pkg::ST_MAC;
				end
			end
			cpse_pkg::ST_NEXT: begin
				n_d = '0;
				state_d = cpse_pkg::ST_IADDR;
				if (c_q != cl) begin
					c_d = c_q + 1'b1;
				end else begin
					c_d = '0;
					state_d = cpse_pkg::ST_POS;
					if (j_q != kl_w) begin
						j_d = j_q + 1'b1;
					end else begin
						j_d = '0;
						if (i_q != kl_h) i_d = i_q + 1'b1;
						else state_d = cpse_pkg::ST_OUT;
					end
				end
			end
			cpse_pkg::ST_OUT: begin
				if (!valid_q || !out_stall) begin
					cmd.out_calc = 1'b1;
					valid_d = 1'b1;
					last_d = (n_q == nl);
					if (n_q == nl) state_d = cpse_pkg::ST_IDLE;
					else n_d = n_q + 1'b1;
				end
			end
			default: state_d = cpse_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != cpse_pkg::ST_IDLE) || valid_q;
	assign out_valid = valid_q;
	assign out_last = last_q;

endmodule

// ===== rtl/cpse_dp.sv =====
// Datapath: stores, address arithmetic, multiply-accumulate and rounding.
module cpse_dp (
	input  logic                      clk,
	input  logic                      ld_en,
	input  logic [1:0]                ld_op,
	input  logic [13:0]               ld_index,
	input  logic signed [15:0]        ld_value,
	input  logic                      start,
	input  logic [5:0]                row,
	input  logic [5:0]                col,
	input  cpse_pkg::geom_t           geom,
	input  cpse_pkg::cmd_t            cmd,
	output cpse_pkg::stat_t           stat,
	output logic signed [15:0]        res_value,
	output logic [cpse_pkg::NCH_W-1:0] res_channel
);

	logic [15:0] img_mem [cpse_pkg::IMAGE_WORDS];
	logic [15:0] wgt_mem [cpse_pkg::WEIGHT_WORDS];
	logic [15:0] bias_mem [cpse_pkg::MAX_OUT_CH];
	logic [cpse_pkg::ACC_W-1:0] acc_q [cpse_pkg::MAX_OUT_CH];

	logic signed [8:0] r0_q, c0_q;
	logic signed [9:0] r_v, cc_v;
	logic inb_q;
	logic [cpse_pkg::ADDR_W-1:0] pix_q, iaddr_q, tap_q, wch_q, wbase_q, waddr;
	logic iok_q, wok_q;
	logic [15:0] img_rd_q, wgt_rd_q;
	logic signed [31:0] prod;
	logic signed [cpse_pkg::ACC_W-1:0] acc_s;
	logic signed [cpse_pkg::ACC_W:0] t;
	logic signed [31:0] q;

	// loads beyond a store are dropped
	always_ff @(posedge clk) begin
		if (ld_en && ld_op == cpse_pkg::OP_LOAD_IMG)
			img_mem[ld_index[cpse_pkg::IMG_AW-1:0]] <= ld_value;
		if (ld_en && ld_op == cpse_pkg::OP_LOAD_WGT)
			wgt_mem[ld_index[cpse_pkg::WGT_AW-1:0]] <= ld_value;
		if (ld_en && ld_op == cpse_pkg::OP_LOAD_BIAS && ld_index < 14'(cpse_pkg::MAX_OUT_CH))
			bias_mem[ld_index[cpse_pkg::NCH_W-1:0]] <= ld_value;
	end

	assign r_v = 10'(r0_q) + $signed({7'd0, cmd.i});
	assign cc_v = 10'(c0_q) + $signed({7'd0, cmd.j});

	always_ff @(posedge clk) begin
		if (start) begin
			r0_q <= 9'($signed({1'b0, row}) * $signed({1'b0, geom.s}))
				- $signed({7'd0, geom.p});
			c0_q <= 9'($signed({1'b0, col}) * $signed({1'b0, geom.s}))
				- $signed({7'd0, geom.p});
		end
		if (cmd.pos_calc) begin
			inb_q <= (r_v >= 0) && (r_v < $signed({3'd0, geom.h}))
				&& (cc_v >= 0) && (cc_v < $signed({3'd0, geom.w}));
			// a tap in the border never uses this pixel address
			pix_q <= cpse_pkg::ADDR_W'(r_v[6:0]) * cpse_pkg::ADDR_W'(geom.w)
				+ cpse_pkg::ADDR_W'(cc_v[6:0]);
			tap_q <= cpse_pkg::ADDR_W'(cmd.i) * cpse_pkg::ADDR_W'(geom.kw)
				+ cpse_pkg::ADDR_W'(cmd.j);
		end
		if (cmd.iaddr_calc) begin
			iaddr_q <= pix_q * cpse_pkg::ADDR_W'(geom.c) + cpse_pkg::ADDR_W'(cmd.c);
			wch_q <= tap_q * cpse_pkg::ADDR_W'(geom.c) + cpse_pkg::ADDR_W'(cmd.c);
		end
		if (cmd.img_rd) begin
			img_rd_q <= img_mem[iaddr_q[cpse_pkg::IMG_AW-1:0]];
			iok_q <= iaddr_q < cpse_pkg::ADDR_W'(cpse_pkg::IMAGE_WORDS);
			wbase_q <= wch_q * cpse_pkg::ADDR_W'(geom.n);
		end
		if (cmd.wgt_rd) begin
			wgt_rd_q <= wgt_mem[waddr[cpse_pkg::WGT_AW-1:0]];
			wok_q <= waddr < cpse_pkg::ADDR_W'(cpse_pkg::WEIGHT_WORDS);
		end
	end

	assign waddr = wbase_q + cpse_pkg::ADDR_W'(cmd.n);

	assign stat.in_bounds = inb_q;
	assign stat.act_zero = !iok_q || (img_rd_q == 16'd0);

	assign prod = $signed(img_rd_q) * $signed(wok_q ? wgt_rd_q : 16'd0);

	always_ff @(posedge clk) begin
		if (cmd.bias_rd)
			acc_q[cmd.n] <= cpse_pkg::ACC_W'($signed(bias_mem[cmd.n])) <<< 8;
		else if (cmd.mac)
			acc_q[cmd.n] <= acc_q[cmd.n] + cpse_pkg::ACC_W'(prod);
	end

	// one guard bit keeps the rounding offset from wrapping the sum
	assign acc_s = $signed(acc_q[cmd.n]);
	assign t = $signed({acc_s[cpse_pkg::ACC_W-1], acc_s}) + 41'sd128;
	always_comb begin
		if ((t >>> 8) > 41'sd32767) q = 32'sd32767;
		else if ((t >>> 8) < -41'sd32768) q = -32'sd32768;
		else q = 32'(t >>> 8);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_calc) begin
			res_value <= q[15:0];
			res_channel <= cmd.n;
		end
	end

endmodule

// ===== rtl/cpse_checker.sv =====
// Port-level checks for the convolution engine, bound to the top level.
module cpse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       stall,
	input logic [1:0] operation,
	input logic       result_valid,
	input logic       result_stall,
	input logic [3:0] channel,
	input logic       last
);

	// a result waiting for its sink holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(channel) && $stable(last))
		else $error("result changed while stalled");

	// no input is taken while results are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> stall)
		else $error("input accepted with result pending");

	// a compute transaction makes the block busy next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall && operation == cpse_pkg::OP_COMPUTE |=> stall)
		else $error("compute did not engage");

	// the first result of a pixel is channel zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> channel == 4'd0)
		else $error("first channel not zero");

endmodule

bind conv2d_pad_stride_engine cpse_checker u_cpse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.valid(valid),
	.stall(stall),
	.operation(operation),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.channel(channel),
	.last(last)
);

// ===== tb/conv2d_pad_stride_engine_tb.sv =====
// Testbench for the convolution engine: directed table, random phases, self-checking.
`timescale 1ns / 100ps

module conv2d_pad_stride_engine_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int N_DIR = 27;
	localparam int N_PHASE = 3;

	typedef struct {
		logic [1:0] op;
		int idx;
		int val;
		int row;
		int col;
		bit fixed;
		int want;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] val;
		logic [3:0] ch;
		logic lst;
	} pixel_out_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic [1:0] operation;
	logic [13:0] index;
	logic signed [15:0] value;
	logic [5:0] out_row;
	logic [5:0] out_col;
	logic result_valid;
	logic result_stall;
	logic signed [15:0] result_value;
	logic [3:0] channel;
	logic last;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;

	conv2d_pad_stride_engine u_top (.*);

	// shadow of the block's stores and registers
	logic signed [15:0] img_mem [cpse_pkg::IMAGE_WORDS];
	logic signed [15:0] wgt_mem [cpse_pkg::WEIGHT_WORDS];
	logic signed [15:0] bias_mem [cpse_pkg::MAX_OUT_CH];
	logic [6:0] geo_h, geo_w, geo_c;
	logic [4:0] geo_n;
	logic [2:0] geo_kh, geo_kw, geo_s;
	logic [1:0] geo_p;

	pixel_out_t pending_q[$];
	int errors;
	int cycles;
	int burst_left;
	bit gaps_on;
	int stall_pct;

	stim_row_t dir_tab [N_DIR] = '{
		'{cpse_pkg::OP_LOAD_BIAS, 0, 0, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_IMG, 0, -32768, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_WGT, 0, -32768, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, 32767},
		'{cpse_pkg::OP_LOAD_WGT, 0, 32767, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, -32768},
		'{cpse_pkg::OP_LOAD_IMG, 0, 1, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_WGT, 0, 128, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, 1},
		'{cpse_pkg::OP_LOAD_WGT, 0, 127, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, 0},
		'{cpse_pkg::OP_LOAD_IMG, 0, -1, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_WGT, 0, 128, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, 0},
		'{cpse_pkg::OP_LOAD_WGT, 0, 129, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, -1},
		'{cpse_pkg::OP_LOAD_IMG, 0, 0, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_BIAS, 0, 32767, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, 32767},
		'{cpse_pkg::OP_LOAD_BIAS, 0, -32768, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 63, 63, 1, -32768},
		// bias loads past the store must not land
		'{cpse_pkg::OP_LOAD_BIAS, 16383, 5, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_BIAS, 16, 7, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_IMG, 16383, 21845, 0, 0, 0, 0},
		'{cpse_pkg::OP_LOAD_WGT, 16383, -21846, 0, 0, 0, 0},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 1, 0, 1, -32768},
		'{cpse_pkg::OP_COMPUTE, 0, 0, 0, 0, 0, 0}
	};

	int phase_cfg [N_PHASE][8] = '{
		'{2, 2, 2, 2, 2, 2, 2, 1},
		'{0, 0, 0, 0, 0, 0, 7, 0},
		'{1, 2, 1, 31, 1, 1, 3, 3}
	};

	int phase_items [N_PHASE] = '{10, 8, 6};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff(int raw, int hi);
		if (raw == 0)
			return 1;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// walk the window for one output pixel and queue one word per filter
	function automatic void predict_pixel(int row, int col);
		int nh, nw, nc, nn, nkh, nkw, ns, r0, c0, r, cc, ia, wa;
		logic signed [39:0] acc [cpse_pkg::MAX_OUT_CH];
		longint t;
		longint q;
		pixel_out_t po;
		nh = eff(geo_h, cpse_pkg::MAX_DIM);
		nw = eff(geo_w, cpse_pkg::MAX_DIM);
		nc = eff(geo_c, cpse_pkg::MAX_DIM);
		nn = eff(geo_n, cpse_pkg::MAX_OUT_CH);
		nkh = eff(geo_kh, cpse_pkg::MAX_KERNEL);
		nkw = eff(geo_kw, cpse_pkg::MAX_KERNEL);
		ns = eff(geo_s, 4);
		r0 = row * ns - int'(geo_p);
		c0 = col * ns - int'(geo_p);
		for (int n = 0; n < nn; n++)
			acc[n] = 40'(longint'(bias_mem[n]) * 256);
		for (int i = 0; i < nkh; i++) begin
			r = r0 + i;
			if (r < 0 || r >= nh)
				continue;
			for (int j = 0; j < nkw; j++) begin
				cc = c0 + j;
				if (cc < 0 || cc >= nw)
					continue;
				for (int c = 0; c < nc; c++) begin
					ia = (r * nw + cc) * nc + c;
					if (ia >= cpse_pkg::IMAGE_WORDS || img_mem[ia] == 0)
						continue;
					for (int n = 0; n < nn; n++) begin
						wa = ((i * nkw + j) * nc + c) * nn + n;
						if (wa < cpse_pkg::WEIGHT_WORDS)
							acc[n] = acc[n]
								+ 40'(longint'(img_mem[ia]) * longint'(wgt_mem[wa]));
					end
				end
			end
		end
		for (int n = 0; n < nn; n++) begin
			t = longint'(acc[n]) + 128;
			q = t >>> 8;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			po.val = 16'(q);
			po.ch = 4'(n);
			po.lst = (n == nn - 1);
			pending_q.push_back(po);
		end
	endfunction

	function automatic void apply_item(logic [1:0] op, int idx, int val, int row, int col);
		case (op)
			cpse_pkg::OP_LOAD_IMG: img_mem[idx] = 16'(val);
			cpse_pkg::OP_LOAD_WGT: wgt_mem[idx] = 16'(val);
			cpse_pkg::OP_LOAD_BIAS: begin
				if (idx < cpse_pkg::MAX_OUT_CH)
					bias_mem[idx] = 16'(val);
			end
			default: predict_pixel(row, col);
		endcase
	endfunction

	// drive one transaction; hold it until the block takes it
	task automatic send_item(logic [1:0] op, int idx, int val, int row, int col,
			bit fixed = 0, int want = 0);
		pixel_out_t po;
		int g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				g = $urandom_range(1, 8);
				@(negedge clk);
				valid <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		valid <= 1'b1;
		operation <= op;
		index <= 14'(idx);
		value <= 16'(val);
		out_row <= 6'(row);
		out_col <= 6'(col);
		do @(posedge clk); while (stall);
		if (fixed) begin
			po.val = 16'(want);
			po.ch = '0;
			po.lst = 1'b1;
			pending_q.push_back(po);
		end else begin
			apply_item(op, idx, val, row, col);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		// loads leave no result; let any last one settle
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] ri, int data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= 7'(data);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (ri)
			cpse_pkg::REG_IN_HEIGHT: geo_h = 7'(data);
			cpse_pkg::REG_IN_WIDTH: geo_w = 7'(data);
			cpse_pkg::REG_IN_CHANNELS: geo_c = 7'(data);
			cpse_pkg::REG_OUT_CHANNELS: geo_n = 5'(data);
			cpse_pkg::REG_KERNEL_HEIGHT: geo_kh = 3'(data);
			cpse_pkg::REG_KERNEL_WIDTH: geo_kw = 3'(data);
			cpse_pkg::REG_STRIDE: geo_s = 3'(data);
			default: geo_p = 2'(data);
		endcase
	endtask

	function automatic int rand_word();
		if ($urandom_range(0, 4) == 0)
			return 0;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic run_phase(int ph);
		int img_n, wgt_n, nn, oh, ow, items, sel, row, col;
		for (int k = 0; k < 8; k++)
			write_reg(3'(k), phase_cfg[ph][k]);
		nn = eff(geo_n, cpse_pkg::MAX_OUT_CH);
		img_n = eff(geo_h, cpse_pkg::MAX_DIM) * eff(geo_w, cpse_pkg::MAX_DIM)
			* eff(geo_c, cpse_pkg::MAX_DIM);
		wgt_n = eff(geo_kh, cpse_pkg::MAX_KERNEL) * eff(geo_kw, cpse_pkg::MAX_KERNEL)
			* eff(geo_c, cpse_pkg::MAX_DIM) * nn;
		if (img_n > cpse_pkg::IMAGE_WORDS)
			img_n = cpse_pkg::IMAGE_WORDS;
		if (wgt_n > cpse_pkg::WEIGHT_WORDS)
			wgt_n = cpse_pkg::WEIGHT_WORDS;
		gaps_on = (ph % 3 != 1);
		stall_pct = (ph % 3) * 35;
		for (int a = 0; a < img_n; a++)
			send_item(cpse_pkg::OP_LOAD_IMG, a, rand_word(), 0, 0);
		for (int a = 0; a < wgt_n; a++)
			send_item(cpse_pkg::OP_LOAD_WGT, a, rand_word(), 0, 0);
		for (int a = 0; a < nn; a++)
			send_item(cpse_pkg::OP_LOAD_BIAS, a, rand_word(), 0, 0);
		oh = (eff(geo_h, cpse_pkg::MAX_DIM) + 2 * geo_p - eff(geo_kh, cpse_pkg::MAX_KERNEL))
			/ eff(geo_s, 4) + 1;
		ow = (eff(geo_w, cpse_pkg::MAX_DIM) + 2 * geo_p - eff(geo_kw, cpse_pkg::MAX_KERNEL))
			/ eff(geo_s, 4) + 1;
		if (oh < 1)
			oh = 1;
		if (ow < 1)
			ow = 1;
		items = phase_items[ph];
		for (int k = 0; k < items; k++) begin
			sel = $urandom_range(0, 9);
			if (k == items / 2)
				drain();
			if (sel < 7) begin
				row = (sel == 0) ? $urandom_range(0, 63) : $urandom_range(0, oh);
				col = (sel == 0) ? $urandom_range(0, 63) : $urandom_range(0, ow);
				send_item(cpse_pkg::OP_COMPUTE, 0, 0, row, col);
			end else if (sel == 7) begin
				send_item(cpse_pkg::OP_LOAD_IMG, $urandom_range(0, img_n - 1),
					rand_word(), 0, 0);
			end else if (sel == 8) begin
				send_item(cpse_pkg::OP_LOAD_WGT, $urandom_range(0, wgt_n - 1),
					rand_word(), 0, 0);
			end else begin
				send_item(cpse_pkg::OP_LOAD_BIAS, $urandom_range(0, 31), rand_word(), 0, 0);
			end
		end
		drain();
	endtask

	// check each result transaction against the oldest expected word
	always @(posedge clk) begin
		pixel_out_t po;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result: value %0d channel %0d", result_value, channel);
				errors++;
			end else begin
				po = pending_q.pop_front();
				if (result_value !== po.val) begin
					$error("result_value: expected %0d, got %0d", po.val, result_value);
					errors++;
				end
				if (channel !== po.ch) begin
					$error("channel: expected %0d, got %0d", po.ch, channel);
					errors++;
				end
				if (last !== po.lst) begin
					$error("last: expected %0d, got %0d", po.lst, last);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL conv2d_pad_stride_engine");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1;
		stall_pct = 20;
		arst_n = 1'b0;
		valid = 1'b0;
		operation = cpse_pkg::OP_LOAD_IMG;
		index = '0;
		value = '0;
		out_row = '0;
		out_col = '0;
		cfg_we = 1'b0;
		cfg_index = cpse_pkg::REG_IN_HEIGHT;
		cfg_data = '0;
		result_stall = 1'b0;
		geo_h = 7'd1;
		geo_w = 7'd1;
		geo_c = 7'd1;
		geo_n = 5'd1;
		geo_kh = 3'd1;
		geo_kw = 3'd1;
		geo_s = 3'd1;
		geo_p = 2'd0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		// fixed rows leave the shadow alone, so mirror their loads
		for (int k = 0; k < N_DIR; k++)
			send_item(dir_tab[k].op, dir_tab[k].idx, dir_tab[k].val, dir_tab[k].row,
				dir_tab[k].col, dir_tab[k].fixed, dir_tab[k].want);
		drain();
		for (int ph = 0; ph < N_PHASE; ph++)
			run_phase(ph);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("PASS conv2d_pad_stride_engine");
		else
			$display("FAIL conv2d_pad_stride_engine");
		$finish;
	end

endmodule
